### rtl/rpq_pkg.sv
// ----------------------------------------------------------------------------
// rpq_pkg
// Types and constants shared by the radar pulse qualifier modules.
// ----------------------------------------------------------------------------
package rpq_pkg;

  // One phy-error report as it arrives.
  typedef struct packed {
    logic [7:0]  phy_error_code;
    logic [11:0] data_length;
    logic [7:0]  ctl_rssi_raw;
    logic [7:0]  ext_rssi_raw;
    logic [7:0]  bw_info;
    logic [7:0]  ext_pulse_length;
    logic [7:0]  pri_pulse_length;
    logic [63:0] timestamp;
  } in_item_t;

  // One qualified pulse.
  typedef struct packed {
    logic [12:0] pulse_freq_mhz;
    logic [63:0] pulse_time;
    logic [7:0]  width_us;
    logic [6:0]  pulse_rssi;
    logic        on_extension;
    logic        last;
  } out_item_t;

  // Stage advance enables handed to the width conversion pipeline.
  typedef struct packed {
    logic s2_en;
    logic s3_en;
  } rpq_adv_t;

  // Error codes that carry a radar report.
  localparam logic [7:0] CODE_RADAR     = 8'd5;
  localparam logic [7:0] CODE_FALSE_EXT = 8'd24;

  // Channel selection taken from the low bits of the info byte.
  localparam logic [1:0] SEL_NONE = 2'd0;
  localparam logic [1:0] SEL_PRI  = 2'd1;
  localparam logic [1:0] SEL_EXT  = 2'd2;
  localparam logic [1:0] SEL_BOTH = 2'd3;

  // Configuration register indexes.
  localparam logic [7:0] CFG_CHANNEL_MHZ = 8'd0;
  localparam logic [7:0] CFG_FAST_CLOCK  = 8'd1;
  localparam logic [7:0] CFG_HT40_PLUS   = 8'd2;

  localparam logic [12:0] CHANNEL_RESET = 13'd5180;
  localparam logic [12:0] EXT_OFFSET    = 13'd20;

  // RSSI margins of the single-channel rules.
  localparam logic [7:0] PRI_MARGIN = 8'd3;
  localparam logic [7:0] EXT_MARGIN = 8'd12;

  // Duration tick lengths in ns and rounding to microseconds.
  localparam int unsigned NS_SLOW = 800;
  localparam int unsigned NS_FAST = 8000 / 11;
  localparam logic [9:0]  TICK_SLOW_NS = 10'(NS_SLOW);
  localparam logic [9:0]  TICK_FAST_NS = 10'(NS_FAST);
  localparam logic [17:0] ROUND_NS     = 18'd500;

  // Division by 1000 as a multiply by a rounded-up reciprocal. The error term
  // times the largest rounded value stays below two to the shift, so the
  // quotient is exact over the whole range.
  localparam int unsigned RECIP_SHIFT = 28;
  localparam int unsigned NS_PER_US   = 1000;
  localparam logic [18:0] RECIP_K =
    19'(((64'd1 << RECIP_SHIFT) + NS_PER_US - 1) / NS_PER_US);

endpackage

### rtl/rpq_width_pipe.sv
// ----------------------------------------------------------------------------
// rpq_width_pipe
// Two register stages turning a duration in ticks into rounded microseconds.
// ----------------------------------------------------------------------------
module rpq_width_pipe
  import rpq_pkg::*;
(
  input  logic       clk,
  input  rpq_adv_t   adv,
  input  logic       fast_clock,
  input  logic [7:0] dur_ticks,
  output logic [7:0] width_us
);

  logic [17:0] ns_rnd_r, ns_rnd_nxt;
  logic [35:0] prod_r, prod_nxt;

  always_comb begin
    ns_rnd_nxt = 18'(dur_ticks) * 18'(fast_clock ? TICK_FAST_NS : TICK_SLOW_NS) + ROUND_NS;
    prod_nxt   = 36'(37'(ns_rnd_r) * 37'(RECIP_K));
  end

  always_ff @(posedge clk) begin
    if (adv.s2_en) begin
      ns_rnd_r <= ns_rnd_nxt;
    end
    if (adv.s3_en) begin
      prod_r <= prod_nxt;
    end
  end

  // Quotient bits; the value never exceeds 204, so the top bits are zero.
  assign width_us = prod_r[RECIP_SHIFT +: 8];

endmodule

### rtl/radar_pulse_qualifier.sv
// ----------------------------------------------------------------------------
// radar_pulse_qualifier
// Qualifies radar phy-error reports and emits zero, one or two pulses each.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  in_       input      in_valid / in_stall    in_data  (in_item_t)
//  out_      output     out_valid / out_stall  out_data (out_item_t)
//  cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  Five stages: decode, tick multiply, reciprocal multiply, pulse emitter and
//  output register, which each report passes through in that order.
//  A new report enters every cycle unless out_stall or a dual-pulse report in the
//  emitter holds the pipeline; such a report occupies the emitter for both pulses.
//  Dropped reports are accepted and leave a bubble behind.
//  Reset is synchronous and clears valid bits, the emitter phase and the config registers only.
//  A stall holds each occupied stage whose successor is held; empty stages still fill.
// ----------------------------------------------------------------------------
module radar_pulse_qualifier
  import rpq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [12:0] channel_mhz_r;
  logic        fast_clock_r;
  logic        ht40_plus_r;

  // Decode stage.
  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_dur_r, s1_dur_nxt;
  logic [6:0]  s1_rssi_r, s1_rssi_nxt;
  logic [1:0]  s1_sel_r;
  logic [63:0] s1_ts_r;

  logic        s2_valid_r, s3_valid_r;
  logic [6:0]  s2_rssi_r, s3_rssi_r;
  logic [1:0]  s2_sel_r, s3_sel_r;
  logic [63:0] s2_ts_r, s3_ts_r;

  // Emitter stage.
  logic        e_valid_r, e_valid_nxt;
  logic        e_phase_r, e_phase_nxt;
  logic [7:0]  e_width_r;
  logic [6:0]  e_rssi_r;
  logic [1:0]  e_sel_r;
  logic [63:0] e_ts_r;

  logic        out_valid_r;
  out_item_t   out_data_r, out_data_nxt;

  logic        o_ready, e_fire, e_done, e_ready, s1_en;
  rpq_adv_t    adv;
  logic [7:0]  width_us;

  logic [1:0]  sel;
  logic [7:0]  ctl_c, ext_c;
  logic        code_ok, keep;
  logic        is_ext;
  logic [12:0] ext_freq;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_mhz_r <= CHANNEL_RESET;
      fast_clock_r  <= 1'b0;
      ht40_plus_r   <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CHANNEL_MHZ: channel_mhz_r <= cfg_data[12:0];
        CFG_FAST_CLOCK:  fast_clock_r  <= cfg_data[0];
        CFG_HT40_PLUS:   ht40_plus_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Back-pressure chain: a stage moves when it is empty or its successor moves.
  always_comb begin
    o_ready   = !out_valid_r || !out_stall;
    e_fire    = e_valid_r && o_ready;
    e_done    = e_fire && ((e_sel_r != SEL_BOTH) || e_phase_r);
    e_ready   = !e_valid_r || e_done;
    adv.s3_en = !s3_valid_r || e_ready;
    adv.s2_en = !s2_valid_r || adv.s3_en;
    s1_en     = !s1_valid_r || adv.s2_en;
  end

  assign in_stall = !s1_en;

  // Report qualification and selection.
  always_comb begin
    sel     = in_data.bw_info[1:0];
    ctl_c   = in_data.ctl_rssi_raw[7] ? 8'd0 : in_data.ctl_rssi_raw;
    ext_c   = in_data.ext_rssi_raw[7] ? 8'd0 : in_data.ext_rssi_raw;
    code_ok = (in_data.phy_error_code == CODE_RADAR) ||
              (in_data.phy_error_code == CODE_FALSE_EXT);
    case (sel)
      SEL_PRI: begin
        s1_dur_nxt  = in_data.pri_pulse_length;
        s1_rssi_nxt = (ext_c >= ctl_c + PRI_MARGIN) ? 7'd0 : ctl_c[6:0];
      end
      SEL_EXT: begin
        s1_dur_nxt  = in_data.ext_pulse_length;
        s1_rssi_nxt = (ctl_c >= ext_c + EXT_MARGIN) ? 7'd0 : ext_c[6:0];
      end
      SEL_BOTH: begin
        s1_dur_nxt  = (in_data.ext_pulse_length >= in_data.pri_pulse_length) ?
                      in_data.ext_pulse_length : in_data.pri_pulse_length;
        s1_rssi_nxt = (ctl_c < ext_c) ? ext_c[6:0] : ctl_c[6:0];
      end
      default: begin
        s1_dur_nxt  = 8'd0;
        s1_rssi_nxt = 7'd0;
      end
    endcase
    keep = code_ok && (in_data.data_length != 12'd0) && (sel != SEL_NONE) &&
           (s1_rssi_nxt != 7'd0);
    s1_valid_nxt = in_valid && keep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_r <= s1_valid_nxt;
      end
      if (adv.s2_en) begin
        s2_valid_r <= s1_valid_r;
      end
      if (adv.s3_en) begin
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_dur_r  <= s1_dur_nxt;
      s1_rssi_r <= s1_rssi_nxt;
      s1_sel_r  <= sel;
      s1_ts_r   <= in_data.timestamp;
    end
    if (adv.s2_en) begin
      s2_rssi_r <= s1_rssi_r;
      s2_sel_r  <= s1_sel_r;
      s2_ts_r   <= s1_ts_r;
    end
    if (adv.s3_en) begin
      s3_rssi_r <= s2_rssi_r;
      s3_sel_r  <= s2_sel_r;
      s3_ts_r   <= s2_ts_r;
    end
  end

  rpq_width_pipe u_width (
    .clk        (clk),
    .adv        (adv),
    .fast_clock (fast_clock_r),
    .dur_ticks  (s1_dur_r),
    .width_us   (width_us)
  );

  // Emitter: a report with both pulses sends the primary first, then stays in the
  // emitter for the extension pulse.
  always_comb begin
    e_valid_nxt = e_valid_r;
    e_phase_nxt = e_phase_r;
    if (e_ready) begin
      e_valid_nxt = s3_valid_r;
      e_phase_nxt = 1'b0;
    end else if (e_fire) begin
      e_phase_nxt = 1'b1;
    end

    is_ext   = (e_sel_r == SEL_EXT) || e_phase_r;
    ext_freq = ht40_plus_r ? (channel_mhz_r + EXT_OFFSET) : (channel_mhz_r - EXT_OFFSET);
    out_data_nxt.pulse_freq_mhz = is_ext ? ext_freq : channel_mhz_r;
    out_data_nxt.pulse_time     = e_ts_r;
    out_data_nxt.width_us       = e_width_r;
    out_data_nxt.pulse_rssi     = e_rssi_r;
    out_data_nxt.on_extension   = is_ext;
    out_data_nxt.last           = (e_sel_r != SEL_BOTH) || e_phase_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r   <= 1'b0;
      e_phase_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      e_valid_r <= e_valid_nxt;
      e_phase_r <= e_phase_nxt;
      if (o_ready) begin
        out_valid_r <= e_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e_ready) begin
      e_width_r <= width_us;
      e_rssi_r  <= s3_rssi_r;
      e_sel_r   <= s3_sel_r;
      e_ts_r    <= s3_ts_r;
    end
    if (e_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The second half of a report only exists for reports with both pulses.
  a_phase_both: assert property (@(posedge clk) disable iff (!rst_n)
    e_phase_r |-> (e_valid_r && (e_sel_r == SEL_BOTH)))
    else $error("emitter in second phase without a dual-pulse report");

  // A primary pulse that is not last is followed at once by its extension pulse.
  a_ext_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_data.last) |=> (out_valid && out_data.on_extension))
    else $error("extension pulse did not follow its primary pulse");

  // An empty decode stage never holds off an input transaction.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with an empty decode stage");

endmodule
